### hdl/imufp_pkg.sv
// Shared types and constants for the IMU frame parser.
package imufp_pkg;

  localparam int MAX_BODY_DEF = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EULER_CODE    = 2'd2;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'd85;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd170;
  localparam logic [7:0] EULER_CODE_RST    = 8'd1;

  // Frame overhead counted by the length byte: two headers, length, function.
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
  // Body positions that carry the yaw word, and the smallest body holding it
  // plus the checksum byte.
  localparam int YAW_FIRST_IDX  = 8;
  localparam int YAW_LAST_IDX   = 11;
  localparam int YAW_MIN_BODY   = 13;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LEN,
    PH_FUNC,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] euler_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  frame_code;
    logic        sum_ok;
    logic        yaw_updated;
    logic [31:0] yaw_raw_bits;
  } res_t;

endpackage

### hdl/imufp_cfg.sv
// Configuration register file for the IMU frame parser.
module imufp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [imufp_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [7:0]                          wr_data,
  output imufp_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= imufp_pkg::HEADER_FIRST_RST;
      cfg.header_second <= imufp_pkg::HEADER_SECOND_RST;
      cfg.euler_code    <= imufp_pkg::EULER_CODE_RST;
    end else if (wr_en) begin
      case (wr_index)
        imufp_pkg::CFG_HEADER_FIRST:  cfg.header_first  <= wr_data;
        imufp_pkg::CFG_HEADER_SECOND: cfg.header_second <= wr_data;
        imufp_pkg::CFG_EULER_CODE:    cfg.euler_code    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/imufp_parser.sv
// Byte-at-a-time frame state machine with running checksum and yaw capture.
module imufp_parser #(
  parameter int MAX_BODY = imufp_pkg::MAX_BODY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_en,
  input  logic [7:0]        byte_in,
  input  imufp_pkg::cfg_t   cfg,
  output logic              res_valid,
  output imufp_pkg::res_t   res
);

  localparam int IDX_W = $clog2(MAX_BODY);

  imufp_pkg::phase_t phase, phase_next;
  logic [7:0]        length_byte, length_byte_next;
  logic [7:0]        code_byte, code_byte_next;
  logic [IDX_W-1:0]  body_index, body_index_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [31:0]       yaw_staging, yaw_staging_next;
  logic [31:0]       yaw_committed, yaw_committed_next;

  logic [7:0] dlen;
  logic [8:0] idx_plus1;
  logic       bad_len;
  logic       ok;
  logic       upd;

  assign dlen      = (length_byte >= imufp_pkg::FRAME_OVERHEAD) ?
                     length_byte - imufp_pkg::FRAME_OVERHEAD : 8'd0;
  assign bad_len   = (dlen == 8'd0) || (9'(dlen) > 9'(MAX_BODY));
  assign idx_plus1 = 9'(body_index) + 9'd1;
  assign ok        = (running_sum == byte_in);
  assign upd       = ok && (code_byte == cfg.euler_code) &&
                     (9'(dlen) >= 9'(imufp_pkg::YAW_MIN_BODY));

  always_comb begin
    phase_next         = phase;
    length_byte_next   = length_byte;
    code_byte_next     = code_byte;
    body_index_next    = body_index;
    running_sum_next   = running_sum;
    yaw_staging_next   = yaw_staging;
    yaw_committed_next = yaw_committed;
    res_valid          = 1'b0;
    res.frame_code     = code_byte;
    res.sum_ok         = ok;
    res.yaw_updated    = upd;
    res.yaw_raw_bits   = upd ? yaw_staging_next : yaw_committed;
    if (byte_en) begin
      case (phase)
        imufp_pkg::PH_HUNT1: begin
          if (byte_in == cfg.header_first) phase_next = imufp_pkg::PH_HUNT2;
        end
        imufp_pkg::PH_HUNT2: begin
          phase_next = (byte_in == cfg.header_second) ? imufp_pkg::PH_LEN
                                                      : imufp_pkg::PH_HUNT1;
        end
        imufp_pkg::PH_LEN: begin
          length_byte_next = byte_in;
          phase_next       = imufp_pkg::PH_FUNC;
        end
        imufp_pkg::PH_FUNC: begin
          code_byte_next   = byte_in;
          body_index_next  = '0;
          running_sum_next = cfg.header_first + cfg.header_second + length_byte + byte_in;
          phase_next       = imufp_pkg::PH_BODY;
        end
        imufp_pkg::PH_BODY: begin
          if (bad_len) begin
            // The first body byte is swallowed and the hunt starts over.
            phase_next = imufp_pkg::PH_HUNT1;
          end else begin
            if (body_index >= IDX_W'(imufp_pkg::YAW_FIRST_IDX) &&
                body_index <= IDX_W'(imufp_pkg::YAW_LAST_IDX)) begin
              yaw_staging_next[8*body_index[1:0] +: 8] = byte_in;
            end
            if (idx_plus1 < 9'(dlen)) begin
              running_sum_next = running_sum + byte_in;
              body_index_next  = idx_plus1[IDX_W-1:0];
            end else begin
              // Last body byte is the checksum.
              if (upd) yaw_committed_next = yaw_staging_next;
              phase_next      = imufp_pkg::PH_HUNT1;
              body_index_next = '0;
              res_valid       = 1'b1;
            end
          end
        end
        default: phase_next = imufp_pkg::PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= imufp_pkg::PH_HUNT1;
      length_byte   <= '0;
      code_byte     <= '0;
      body_index    <= '0;
      running_sum   <= '0;
      yaw_staging   <= '0;
      yaw_committed <= '0;
    end else begin
      phase         <= phase_next;
      length_byte   <= length_byte_next;
      code_byte     <= code_byte_next;
      body_index    <= body_index_next;
      running_sum   <= running_sum_next;
      yaw_staging   <= yaw_staging_next;
      yaw_committed <= yaw_committed_next;
    end
  end

endmodule

### hdl/imufp_out_buf.sv
// Result register with a skid stage so input bytes keep flowing under a stall.
module imufp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  imufp_pkg::res_t   push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output imufp_pkg::res_t   out_data
);

  logic            skid_valid;
  imufp_pkg::res_t skid_data;
  logic            pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // No push can arrive while the skid stage is occupied.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (out_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

endmodule

### hdl/imu_frame_parser_top.sv
// IMU frame parser: accepts one byte per cycle unless stalled and reports each finished frame.
// A frame result is registered into the result register or its skid stage when its checksum byte is taken.
// Throughput: one byte per cycle; the input stalls only when both the result
// register and its skid stage hold undelivered results.
// Reset (rst, synchronous) restores the default header and Euler codes, returns
// the parser to the first-header hunt and clears the committed yaw word.
module imu_frame_parser_top #(
  parameter int MAX_BODY = imufp_pkg::MAX_BODY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       frame_code,
  output logic                             sum_ok,
  output logic                             yaw_updated,
  output logic [31:0]                      yaw_raw_bits,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [imufp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data
);

  imufp_pkg::cfg_t cfg;
  imufp_pkg::res_t res;
  imufp_pkg::res_t out_data;
  logic            res_valid;
  logic            buf_full;
  logic            in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  imufp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  imufp_parser #(.MAX_BODY(MAX_BODY)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (in_accept),
    .byte_in   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  imufp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign frame_code   = out_data.frame_code;
  assign sum_ok       = out_data.sum_ok;
  assign yaw_updated  = out_data.yaw_updated;
  assign yaw_raw_bits = out_data.yaw_raw_bits;

endmodule

### hdl/imufp_checker.sv
// Port-level checks for the IMU frame parser, bound to the top level.
module imufp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic sum_ok,
  input logic yaw_updated
);

  // A result held under stall stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A new result only follows an accepted byte.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted byte");

  // A yaw commit requires a good checksum.
  a_yaw_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && yaw_updated |-> sum_ok)
    else $error("yaw committed on a bad checksum");

  // Input backpressure only starts while the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule

bind imu_frame_parser_top imufp_checker u_imufp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .sum_ok      (sum_ok),
  .yaw_updated (yaw_updated)
);

### verif/testbench.sv
// Self-checking testbench for the IMU frame parser: directed, random and back-pressure traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_BODY        = imufp_pkg::MAX_BODY_DEF;
  localparam int          CLK_PERIOD      = 10;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PHASE_BYTES     = 50;

  typedef enum logic [1:0] {LEAD_NONE, LEAD_FALSE_START, LEAD_NOISE} lead_t;
  typedef enum logic [1:0] {WANT_NONE, WANT_TYPED, WANT_PREDICTED} want_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_t;

  typedef struct packed {
    lead_t             lead;
    logic [7:0]        len;
    logic [7:0]        code;
    logic [7:0]        fill;
    logic [31:0]       yaw;
    logic              good_sum;
    want_t             want_kind;
    imufp_pkg::res_t   want;
  } frame_row_t;

  typedef struct {
    bit              typed;
    imufp_pkg::res_t want;
  } row_result_t;

  // Directed frames, sent with the reset header and Euler codes.
  localparam frame_row_t DIRECTED_ROWS [18] = '{
    '{LEAD_NONE, 8'd5, 8'h00, 8'h00, 32'h0, 1'b1, WANT_TYPED,
      '{8'h00, 1'b1, 1'b0, 32'h0000_0000}},
    '{LEAD_NONE, 8'd5, 8'h00, 8'h00, 32'h0, 1'b0, WANT_TYPED,
      '{8'h00, 1'b0, 1'b0, 32'h0000_0000}},
    '{LEAD_NONE, 8'd17, 8'h01, 8'h00, 32'h3F80_0000, 1'b1, WANT_TYPED,
      '{8'h01, 1'b1, 1'b1, 32'h3F80_0000}},
    '{LEAD_NONE, 8'd17, 8'h01, 8'hFF, 32'h1234_5678, 1'b0, WANT_TYPED,
      '{8'h01, 1'b0, 1'b0, 32'h3F80_0000}},
    '{LEAD_NONE, 8'd16, 8'h01, 8'h5A, 32'hC049_0FDB, 1'b1, WANT_TYPED,
      '{8'h01, 1'b1, 1'b0, 32'h3F80_0000}},
    '{LEAD_NONE, 8'd20, 8'h02, 8'h00, 32'h1111_1111, 1'b1, WANT_TYPED,
      '{8'h02, 1'b1, 1'b0, 32'h3F80_0000}},
    '{LEAD_NONE, 8'd4, 8'h01, 8'h55, 32'h0, 1'b1, WANT_NONE, '0},
    '{LEAD_NONE, 8'd0, 8'h01, 8'hAA, 32'h0, 1'b1, WANT_NONE, '0},
    '{LEAD_NONE, 8'd3, 8'h01, 8'h00, 32'h0, 1'b1, WANT_NONE, '0},
    '{LEAD_NONE, 8'(MAX_BODY + 5), 8'h01, 8'h00, 32'h0, 1'b1, WANT_NONE, '0},
    '{LEAD_NONE, 8'(MAX_BODY + 4), 8'h01, 8'hFF, 32'hFFFF_FFFF, 1'b1, WANT_TYPED,
      '{8'h01, 1'b1, 1'b1, 32'hFFFF_FFFF}},
    '{LEAD_NONE, 8'd255, 8'h01, 8'hFF, 32'h0, 1'b1, WANT_NONE, '0},
    '{LEAD_FALSE_START, 8'd5, 8'hFF, 8'h00, 32'h0, 1'b1, WANT_TYPED,
      '{8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF}},
    '{LEAD_NOISE, 8'd17, 8'h01, 8'hFF, 32'h0, 1'b1, WANT_TYPED,
      '{8'h01, 1'b1, 1'b1, 32'h0000_0000}},
    '{LEAD_NONE, 8'd30, 8'h01, 8'h80, 32'h0000_0080, 1'b1, WANT_PREDICTED, '0},
    '{LEAD_NONE, 8'd6, 8'h7F, 8'h01, 32'h0, 1'b1, WANT_PREDICTED, '0},
    '{LEAD_NONE, 8'd18, 8'h01, 8'hA5, 32'h5A5A_5A5A, 1'b0, WANT_PREDICTED, '0},
    '{LEAD_NONE, 8'd17, 8'h00, 8'h33, 32'h0, 1'b1, WANT_PREDICTED, '0}
  };

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      rx_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [7:0]                      frame_code;
  logic                            sum_ok;
  logic                            yaw_updated;
  logic [31:0]                     yaw_raw_bits;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [imufp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                      cfg_data;

  // Header and Euler codes as the parser currently holds them.
  imufp_pkg::cfg_t   active_cfg;
  // Parser state tracked alongside the block.
  imufp_pkg::phase_t pr_phase;
  logic [7:0]        pr_len;
  logic [7:0]        pr_code;
  logic [6:0]        pr_index;
  logic [7:0]        pr_sum;
  logic [31:0]       pr_yaw_stage;
  logic [31:0]       pr_yaw;

  logic [7:0]        tx_bytes[$];
  imufp_pkg::res_t   frames_due[$];
  row_result_t       row_results[$];
  int unsigned       bytes_queued = 0;
  int unsigned       fail_count   = 0;
  int unsigned       cycle_count  = 0;
  bit                hold_off_req = 1'b0;

  imu_frame_parser_top #(
    .MAX_BODY(MAX_BODY)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_code  (frame_code),
    .sum_ok      (sum_ok),
    .yaw_updated (yaw_updated),
    .yaw_raw_bits(yaw_raw_bits),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void offer(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // Advances the tracked parser state by one byte and reports a finished frame.
  task automatic parse_byte(input logic [7:0] b, output bit produced,
                            output imufp_pkg::res_t r);
    int unsigned body_len;
    bit          ok;
    bit          upd;
    produced = 1'b0;
    r = '0;
    case (pr_phase)
      imufp_pkg::PH_HUNT1: begin
        pr_phase = (b == active_cfg.header_first) ? imufp_pkg::PH_HUNT2 : imufp_pkg::PH_HUNT1;
      end
      imufp_pkg::PH_HUNT2: begin
        pr_phase = (b == active_cfg.header_second) ? imufp_pkg::PH_LEN : imufp_pkg::PH_HUNT1;
      end
      imufp_pkg::PH_LEN: begin
        pr_len = b;
        pr_phase = imufp_pkg::PH_FUNC;
      end
      imufp_pkg::PH_FUNC: begin
        pr_code = b;
        pr_index = '0;
        pr_sum = active_cfg.header_first + active_cfg.header_second + pr_len + b;
        pr_phase = imufp_pkg::PH_BODY;
      end
      default: begin
        body_len = (pr_len >= imufp_pkg::FRAME_OVERHEAD) ?
                   pr_len - imufp_pkg::FRAME_OVERHEAD : 0;
        if (body_len == 0 || body_len > MAX_BODY) begin
          pr_phase = imufp_pkg::PH_HUNT1;
        end else begin
          if (pr_index >= imufp_pkg::YAW_FIRST_IDX && pr_index <= imufp_pkg::YAW_LAST_IDX) begin
            pr_yaw_stage[8 * (pr_index - imufp_pkg::YAW_FIRST_IDX) +: 8] = b;
          end
          if (pr_index + 1 < body_len) begin
            pr_sum = pr_sum + b;
            pr_index = pr_index + 1'b1;
          end else begin
            // The last body byte is the checksum itself.
            ok = (pr_sum == b);
            upd = ok && (pr_code == active_cfg.euler_code) &&
                  (body_len >= imufp_pkg::YAW_MIN_BODY);
            if (upd) begin
              pr_yaw = pr_yaw_stage;
            end
            pr_phase = imufp_pkg::PH_HUNT1;
            pr_index = '0;
            produced = 1'b1;
            r.frame_code = pr_code;
            r.sum_ok = ok;
            r.yaw_updated = upd;
            r.yaw_raw_bits = pr_yaw;
          end
        end
      end
    endcase
  endtask

  // Queues one frame built with the current headers; a bad length sends only the dropped byte.
  task automatic queue_frame(input logic [7:0] len_v, input logic [7:0] code_v,
                             input logic [7:0] body[$], input bit good_sum);
    int unsigned body_len;
    logic [7:0]  sum_v;
    body_len = (len_v >= imufp_pkg::FRAME_OVERHEAD) ? len_v - imufp_pkg::FRAME_OVERHEAD : 0;
    sum_v = active_cfg.header_first + active_cfg.header_second + len_v + code_v;
    offer(active_cfg.header_first);
    offer(active_cfg.header_second);
    offer(len_v);
    offer(code_v);
    if (body_len == 0 || body_len > MAX_BODY) begin
      offer(body[0]);
    end else begin
      for (int k = 0; k + 1 < body_len; k++) begin
        offer(body[k]);
        sum_v = sum_v + body[k];
      end
      offer(good_sum ? sum_v : sum_v + 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic queue_random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned body_len;
    logic [7:0]  len_v;
    logic [7:0]  code_v;
    logic [7:0]  body[$];
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(0, 99);
      body.delete();
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) offer(8'($urandom_range(0, 255)));
      end else begin
        if (pick < 16) begin
          len_v = $urandom_range(0, 1) ?
                  8'($urandom_range(0, imufp_pkg::FRAME_OVERHEAD)) :
                  8'($urandom_range(MAX_BODY + imufp_pkg::FRAME_OVERHEAD + 1, 255));
          body_len = 1;
        end else begin
          if (pick < 24) begin
            offer(active_cfg.header_first);
            offer(8'($urandom_range(0, 255)));
          end
          // Mostly short frames, often just long enough to carry yaw, rarely up to the maximum.
          if ($urandom_range(0, 19) == 0) begin
            body_len = $urandom_range(1, MAX_BODY);
          end else if ($urandom_range(0, 2) == 0) begin
            body_len = $urandom_range(imufp_pkg::YAW_MIN_BODY - 1, imufp_pkg::YAW_MIN_BODY + 3);
          end else begin
            body_len = $urandom_range(1, imufp_pkg::YAW_MIN_BODY - 2);
          end
          len_v = 8'(body_len + imufp_pkg::FRAME_OVERHEAD);
        end
        code_v = $urandom_range(0, 1) ? active_cfg.euler_code : 8'($urandom_range(0, 255));
        repeat (body_len) body.push_back(8'($urandom_range(0, 255)));
        queue_frame(len_v, code_v, body, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  task automatic write_reg(input logic [imufp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      imufp_pkg::CFG_HEADER_FIRST:  active_cfg.header_first = val;
      imufp_pkg::CFG_HEADER_SECOND: active_cfg.header_second = val;
      imufp_pkg::CFG_EULER_CODE:    active_cfg.euler_code = val;
      default: ;
    endcase
  endtask

  // Waits until every queued byte is taken and every frame result has come back.
  task automatic drain_frames();
    while (tx_bytes.size() != 0 || in_valid || frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : sender
    int unsigned burst_left;
    int unsigned gap_left;
    burst_left = 0;
    gap_left = 0;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    forever begin
      @(posedge clk);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte <= tx_bytes.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin : receiver
    stall_mode_t mode;
    int          stretch;
    int          tick;
    out_stall <= 1'b0;
    forever begin
      if (hold_off_req) begin
        repeat (HOLD_OFF_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        hold_off_req = 1'b0;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        stretch = $urandom_range(10, 150);
        tick = 0;
        while (tick < stretch && !hold_off_req) begin
          @(posedge clk);
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (tick % 3 == 2);
          endcase
          tick++;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    bit              produced;
    imufp_pkg::res_t frame_res;
    imufp_pkg::res_t want_res;
    row_result_t     row_plan;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        parse_byte(rx_byte, produced, frame_res);
        if (produced) begin
          // Directed rows may carry their own expected result.
          if (row_results.size() != 0) begin
            row_plan = row_results.pop_front();
            frames_due.push_back(row_plan.typed ? row_plan.want : frame_res);
          end else begin
            frames_due.push_back(frame_res);
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          note_failure($sformatf(
            "frame result with none pending: code %02h ok %0b upd %0b yaw %08h",
            frame_code, sum_ok, yaw_updated, yaw_raw_bits));
        end else begin
          want_res = frames_due.pop_front();
          if (frame_code !== want_res.frame_code || sum_ok !== want_res.sum_ok ||
              yaw_updated !== want_res.yaw_updated ||
              yaw_raw_bits !== want_res.yaw_raw_bits) begin
            note_failure($sformatf(
              "frame mismatch: expected code %02h ok %0b upd %0b yaw %08h, got %02h %0b %0b %08h",
              want_res.frame_code, want_res.sum_ok, want_res.yaw_updated, want_res.yaw_raw_bits,
              frame_code, sum_ok, yaw_updated, yaw_raw_bits));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("imu_frame_parser_top test failed");
      $finish;
    end
  end

  initial begin : main
    frame_row_t      row;
    row_result_t     row_plan;
    imufp_pkg::cfg_t phase_cfgs[5];
    logic [7:0]      body[$];

    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= imufp_pkg::CFG_HEADER_FIRST;
    cfg_data <= 8'h00;
    active_cfg.header_first = imufp_pkg::HEADER_FIRST_RST;
    active_cfg.header_second = imufp_pkg::HEADER_SECOND_RST;
    active_cfg.euler_code = imufp_pkg::EULER_CODE_RST;
    pr_phase = imufp_pkg::PH_HUNT1;
    pr_len = '0;
    pr_code = '0;
    pr_index = '0;
    pr_sum = '0;
    pr_yaw_stage = '0;
    pr_yaw = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      case (row.lead)
        // A repeated first header is a bad second header and must not restart the frame.
        LEAD_FALSE_START: begin
          offer(active_cfg.header_first);
          offer(active_cfg.header_first);
        end
        LEAD_NOISE: begin
          offer(8'h00);
          offer(8'hAA);
          offer(8'hFF);
        end
        default: ;
      endcase
      body.delete();
      for (int k = 0; k < 255; k++) begin
        body.push_back((k >= imufp_pkg::YAW_FIRST_IDX && k <= imufp_pkg::YAW_LAST_IDX) ?
                       row.yaw[8 * (k - imufp_pkg::YAW_FIRST_IDX) +: 8] : row.fill);
      end
      if (row.want_kind != WANT_NONE) begin
        row_plan.typed = (row.want_kind == WANT_TYPED);
        row_plan.want = row.want;
        row_results.push_back(row_plan);
      end
      queue_frame(row.len, row.code, body, row.good_sum);
    end
    drain_frames();
    if (row_results.size() != 0) begin
      note_failure($sformatf("%0d directed frames never finished", row_results.size()));
      row_results.delete();
    end

    phase_cfgs[0] = '{8'h00, 8'hFF, 8'h00};
    phase_cfgs[1] = '{8'hFF, 8'h00, 8'hFF};
    phase_cfgs[2] = '{8'h7E, 8'h7E, 8'h80};
    phase_cfgs[3].header_first = 8'($urandom_range(0, 255));
    phase_cfgs[3].header_second = 8'($urandom_range(0, 255));
    phase_cfgs[3].euler_code = 8'($urandom_range(0, 255));
    phase_cfgs[4] = '{imufp_pkg::HEADER_FIRST_RST, imufp_pkg::HEADER_SECOND_RST,
                      imufp_pkg::EULER_CODE_RST};

    foreach (phase_cfgs[p]) begin
      write_reg(imufp_pkg::CFG_HEADER_FIRST, phase_cfgs[p].header_first);
      write_reg(imufp_pkg::CFG_HEADER_SECOND, phase_cfgs[p].header_second);
      write_reg(imufp_pkg::CFG_EULER_CODE, phase_cfgs[p].euler_code);
      queue_random_traffic(PHASE_BYTES);
      drain_frames();
    end

    // Minimal frames while the receiver holds off, so the result stages fill and
    // the parser has to stall its input.
    hold_off_req = 1'b1;
    repeat (20) begin
      body.delete();
      body.push_back(8'($urandom_range(0, 255)));
      queue_frame(8'(imufp_pkg::FRAME_OVERHEAD + 1), 8'($urandom_range(0, 255)), body,
                  $urandom_range(0, 3) != 0);
    end
    drain_frames();

    if (fail_count == 0) begin
      $display("imu_frame_parser_top test passed");
    end else begin
      $display("imu_frame_parser_top test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/imufp_pkg.sv
hdl/imufp_cfg.sv
hdl/imufp_parser.sv
hdl/imufp_out_buf.sv
hdl/imu_frame_parser_top.sv
hdl/imufp_checker.sv
verif/testbench.sv
